>>> design/tss_pkg.sv
package tss_pkg;

  localparam int COUNT_WIDTH_DEF = 8;

  localparam int LIMIT_W    = 37;
  localparam int PROD_W     = 56;
  localparam int SCALED_W   = 57;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [19:0] US_PER_SECOND = 20'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIAL_ENABLE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_COUNT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL_US = 8'd3;

  localparam logic [7:0]  SETTLE_COUNT_RST    = 8'd3;
  localparam logic [7:0]  SKIP_COUNT_RST      = 8'd3;
  localparam logic [23:0] MAX_INTERVAL_US_RST = 24'd100000;

  typedef enum logic [2:0] {
    PH_DISABLED  = 3'd0,
    PH_WAITING   = 3'd1,
    PH_ACTIVE    = 3'd2,
    PH_COMPLETE  = 3'd3,
    PH_CANCELLED = 3'd4,
    PH_INVALID   = 3'd5,
    PH_DEADLINE  = 3'd6
  } tss_phase_e;

  typedef enum logic [1:0] {
    ACT_SERVICE = 2'd0,
    ACT_SKIP    = 2'd1,
    ACT_STOP    = 2'd2
  } tss_action_e;

  typedef struct packed {
    logic        authorized;
    logic        ready_req;
    logic [31:0] rec_epoch;
    logic [31:0] rec_version;
    logic [31:0] tick_rate;
    logic [63:0] tick_stamp;
  } tss_evt_t;

  typedef struct packed {
    tss_action_e action;
    tss_phase_e  trial_state;
    logic        result_valid;
    logic [7:0]  skipped_events;
    logic [31:0] start_version;
    logic [31:0] finish_version;
    logic [63:0] start_ticks;
    logic [63:0] finish_ticks;
  } tss_res_t;

endpackage

>>> design/tss_if.sv
interface tss_event_if;
  logic        valid;
  logic        ready;
  logic        authorized;
  logic        ready_req;
  logic [31:0] rec_epoch;
  logic [31:0] rec_version;
  logic [31:0] tick_rate;
  logic [63:0] tick_stamp;

  modport source (
    output valid, authorized, ready_req, rec_epoch, rec_version, tick_rate, tick_stamp,
    input  ready
  );
  modport sink (
    input  valid, authorized, ready_req, rec_epoch, rec_version, tick_rate, tick_stamp,
    output ready
  );
endinterface

interface tss_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  trial_state;
  logic        result_valid;
  logic [7:0]  skipped_events;
  logic [31:0] start_version;
  logic [31:0] finish_version;
  logic [63:0] start_ticks;
  logic [63:0] finish_ticks;

  modport source (
    output valid, action, trial_state, result_valid, skipped_events, start_version,
           finish_version, start_ticks, finish_ticks,
    input  ready
  );
  modport sink (
    input  valid, action, trial_state, result_valid, skipped_events, start_version,
           finish_version, start_ticks, finish_ticks,
    output ready
  );
endinterface

interface tss_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/timed_skip_window_sequencer_top.sv
// One-shot blackout trial sequencer: each slot event item yields exactly one result item
// (action, trial state and captured start/finish values). An item is registered on
// acceptance in the input register and its result is then registered in the two-entry
// output buffer, from which it is offered; a new item is taken every cycle while
// the receiver keeps up. The deadline check (tick rate * max_interval_us / 1000000) is
// done in the same cycle by comparing elapsed ticks scaled by one million against the
// product, so only a full output buffer holds the input. Write configuration only while
// no item is in flight; any write of trial_enable restarts the trial.
module timed_skip_window_sequencer_top import tss_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tss_event_if.sink    evt_i,
  tss_cfg_if.sink      cfg_i,
  tss_result_if.source res_o
);

  logic         push;
  logic         full;
  tss_res_t     push_data;

  tss_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_i),
    .cfg_i       (cfg_i),
    .fifo_full_i (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tss_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .res_o  (res_o)
  );

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("result pushed into a full output buffer");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> res_o.valid)
    else $error("waiting result dropped");

  a_stop_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.action == ACT_STOP) |-> res_o.result_valid)
    else $error("stop action without a terminal trial state");

endmodule

>>> design/tss_limit.sv
module tss_limit import tss_pkg::*; (
  input  logic [63:0] now_i,
  input  logic [63:0] first_i,
  input  logic [31:0] rate_i,
  input  logic [23:0] max_us_i,
  output logic        late_o
);

  logic [63:0]         elapsed;
  logic [PROD_W-1:0]   allowed;
  logic [SCALED_W-1:0] scaled;

  // Compare elapsed * 1000000 against rate * max_us instead of dividing:
  // elapsed > floor(P / 1000000) holds exactly when elapsed * 1000000 > P.
  // The allowed tick count always stays below 2^LIMIT_W, so a larger elapsed is late.
  always_comb begin
    elapsed = now_i - first_i;
    allowed = {24'd0, rate_i} * {32'd0, max_us_i};
    scaled  = {20'd0, elapsed[LIMIT_W-1:0]} * {37'd0, US_PER_SECOND};
    late_o  = (now_i < first_i) || (elapsed[63:LIMIT_W] != '0) ||
              (scaled > {1'b0, allowed});
  end

endmodule

>>> design/tss_out_fifo.sv
module tss_out_fifo import tss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tss_res_t data_i,
  output logic     full_o,
  tss_result_if.source res_o
);

  logic [1:0] count_q;
  tss_res_t   head_q, tail_q;
  logic       pop;

  assign res_o.valid          = count_q != 2'd0;
  assign pop                  = res_o.valid && res_o.ready;
  assign full_o               = count_q == 2'd2;
  assign res_o.action         = head_q.action;
  assign res_o.trial_state    = head_q.trial_state;
  assign res_o.result_valid   = head_q.result_valid;
  assign res_o.skipped_events = head_q.skipped_events;
  assign res_o.start_version  = head_q.start_version;
  assign res_o.finish_version = head_q.finish_version;
  assign res_o.start_ticks    = head_q.start_ticks;
  assign res_o.finish_ticks   = head_q.finish_ticks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push_i, pop})
      2'b11: begin
        if (count_q == 2'd1) begin
          head_q <= data_i;
        end else begin
          head_q <= tail_q;
          tail_q <= data_i;
        end
      end
      2'b10: begin
        if (count_q == 2'd0) begin
          head_q <= data_i;
        end else begin
          tail_q <= data_i;
        end
      end
      2'b01: begin
        if (count_q == 2'd2) begin
          head_q <= tail_q;
        end
      end
      default: begin
        head_q <= head_q;
      end
    endcase
  end

endmodule

>>> design/tss_core.sv
module tss_core import tss_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tss_event_if.sink    evt_i,
  tss_cfg_if.sink      cfg_i,
  input  logic         fifo_full_i,
  output logic         push_o,
  output tss_res_t     push_data_o
);

  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Input register
  logic     evt_valid_q;
  tss_evt_t evt_q;
  logic     proc;
  logic     accept;

  // Configuration
  logic        enable_q;
  logic [7:0]  settle_count_q;
  logic [7:0]  skip_count_q;
  logic [23:0] max_us_q;
  logic        cfg_we;
  logic        restart;

  // Trial state
  tss_phase_e             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] settle_q, settle_d;
  logic [COUNT_WIDTH-1:0] skip_q, skip_d;
  logic [31:0]            held_epoch_q, held_epoch_d;
  logic [31:0]            held_clock_q, held_clock_d;
  logic [31:0]            first_version_q, first_version_d;
  logic [63:0]            first_ticks_q, first_ticks_d;
  logic [31:0]            last_version_q, last_version_d;
  logic [63:0]            last_ticks_q, last_ticks_d;

  tss_action_e            act;
  logic                   term;
  logic [COUNT_WIDTH-1:0] settle_inc;
  logic [COUNT_WIDTH-1:0] skip_inc;
  logic                   rec_bad;
  logic                   act_bad;
  logic                   late;

  assign proc        = evt_valid_q && !fifo_full_i;
  assign evt_i.ready = !evt_valid_q || proc;
  assign accept      = evt_i.valid && evt_i.ready;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign restart     = cfg_we && (cfg_i.index == CFG_TRIAL_ENABLE);

  tss_limit u_limit (
    .now_i    (evt_q.tick_stamp),
    .first_i  (first_ticks_q),
    .rate_i   (held_clock_q),
    .max_us_i (max_us_q),
    .late_o   (late)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (accept) begin
      evt_valid_q <= 1'b1;
    end else if (proc) begin
      evt_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q.authorized  <= evt_i.authorized;
      evt_q.ready_req   <= evt_i.ready_req;
      evt_q.rec_epoch   <= evt_i.rec_epoch;
      evt_q.rec_version <= evt_i.rec_version;
      evt_q.tick_rate   <= evt_i.tick_rate;
      evt_q.tick_stamp  <= evt_i.tick_stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      settle_count_q <= SETTLE_COUNT_RST;
      skip_count_q   <= SKIP_COUNT_RST;
      max_us_q       <= MAX_INTERVAL_US_RST;
    end else if (cfg_we) begin
      case (cfg_i.index)
        CFG_TRIAL_ENABLE:    enable_q       <= cfg_i.data[0];
        CFG_SETTLE_COUNT:    settle_count_q <= cfg_i.data[7:0];
        CFG_SKIP_COUNT:      skip_count_q   <= cfg_i.data[7:0];
        CFG_MAX_INTERVAL_US: max_us_q       <= cfg_i.data[23:0];
        default:             enable_q       <= enable_q;
      endcase
    end
  end

  always_comb begin
    settle_inc = (settle_q == CNT_MAX) ? settle_q : settle_q + COUNT_WIDTH'(1);
    skip_inc   = (skip_q == CNT_MAX) ? skip_q : skip_q + COUNT_WIDTH'(1);
    rec_bad    = (evt_q.rec_epoch == 32'd0) || (evt_q.rec_version == 32'd0) ||
                 evt_q.rec_version[0] || (evt_q.tick_rate == 32'd0);
    act_bad    = !evt_q.ready_req || (evt_q.rec_epoch != held_epoch_q) ||
                 (evt_q.tick_rate != held_clock_q) || evt_q.rec_version[0];
  end

  // Next trial state
  always_comb begin
    phase_d         = phase_q;
    settle_d        = settle_q;
    skip_d          = skip_q;
    held_epoch_d    = held_epoch_q;
    held_clock_d    = held_clock_q;
    first_version_d = first_version_q;
    first_ticks_d   = first_ticks_q;
    last_version_d  = last_version_q;
    last_ticks_d    = last_ticks_q;
    act             = ACT_SERVICE;
    if (proc && (phase_q == PH_WAITING || phase_q == PH_ACTIVE)) begin
      if (!evt_q.authorized) begin
        phase_d = PH_CANCELLED;
      end else if (phase_q == PH_WAITING) begin
        if (!evt_q.ready_req) begin
          settle_d = '0;
        end else begin
          settle_d = settle_inc;
          if (CMP_W'(settle_inc) >= CMP_W'(settle_count_q)) begin
            if (rec_bad) begin
              phase_d = PH_INVALID;
            end else begin
              held_epoch_d    = evt_q.rec_epoch;
              held_clock_d    = evt_q.tick_rate;
              first_version_d = evt_q.rec_version;
              first_ticks_d   = evt_q.tick_stamp;
              skip_d          = COUNT_WIDTH'(1);
              phase_d         = PH_ACTIVE;
              act             = ACT_SKIP;
            end
          end
        end
      end else begin
        if (act_bad) begin
          phase_d = PH_INVALID;
        end else if (late) begin
          phase_d = PH_DEADLINE;
        end else if (CMP_W'(skip_q) >= CMP_W'(skip_count_q)) begin
          phase_d = PH_COMPLETE;
        end else begin
          skip_d = skip_inc;
          act    = ACT_SKIP;
        end
      end
      if (phase_d != PH_WAITING && phase_d != PH_ACTIVE) begin
        last_version_d = evt_q.rec_version;
        last_ticks_d   = evt_q.tick_stamp;
        act            = ACT_STOP;
      end
    end
  end

  // Result
  always_comb begin
    term = (phase_d == PH_COMPLETE) || (phase_d == PH_CANCELLED) ||
           (phase_d == PH_INVALID) || (phase_d == PH_DEADLINE);
    push_o                     = proc;
    push_data_o.action         = act;
    push_data_o.trial_state    = phase_d;
    push_data_o.result_valid   = term;
    push_data_o.skipped_events = (CMP_W'(skip_d) > CMP_W'(8'hFF)) ? 8'hFF : 8'(skip_d);
    push_data_o.start_version  = first_version_d;
    push_data_o.finish_version = last_version_d;
    push_data_o.start_ticks    = first_ticks_d;
    push_data_o.finish_ticks   = last_ticks_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_DISABLED;
      settle_q        <= '0;
      skip_q          <= '0;
      held_epoch_q    <= '0;
      held_clock_q    <= '0;
      first_version_q <= '0;
      first_ticks_q   <= '0;
      last_version_q  <= '0;
      last_ticks_q    <= '0;
    end else if (restart) begin
      phase_q         <= cfg_i.data[0] ? PH_WAITING : PH_DISABLED;
      settle_q        <= '0;
      skip_q          <= '0;
      held_epoch_q    <= '0;
      held_clock_q    <= '0;
      first_version_q <= '0;
      first_ticks_q   <= '0;
      last_version_q  <= '0;
      last_ticks_q    <= '0;
    end else begin
      phase_q         <= phase_d;
      settle_q        <= settle_d;
      skip_q          <= skip_d;
      held_epoch_q    <= held_epoch_d;
      held_clock_q    <= held_clock_d;
      first_version_q <= first_version_d;
      first_ticks_q   <= first_ticks_d;
      last_version_q  <= last_version_d;
      last_ticks_q    <= last_ticks_d;
    end
  end

endmodule
